/* src/frtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frtc_pkg: shared types and constants for the timebase converter
// Command and status codes, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package frtc_pkg;

  localparam int COUNTER_BITS_DEF = 32;

  localparam int DATA_W      = 32;
  localparam int CMD_W       = 4;
  localparam int ST_W        = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;
  localparam int RATE_W      = 13;
  localparam int RATE_MS_W   = 23;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int ADD_W       = 56;   // holds a 23 x 32 product plus rounding
  localparam int STEP_W      = 5;    // counts DATA_W iterations
  localparam int NS_SHIFT    = 10;
  localparam int COARSE_LSB  = 22;

  localparam logic [ADD_W-1:0] NS_ROUND = ADD_W'(1024 - 1);

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_NS2CNT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_US2CNT  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_MS2CNT  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DUR_NS  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DUR_US  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DUR_MS  = 4'd8;

  // status
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
  localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_DOWN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPS_1024NS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPS_US     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CPS_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_1024NS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_US    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_MS    = 3'd6;

  // register reset values
  localparam logic [RATE_W-1:0]    RST_CPS_1024NS  = 13'd103;
  localparam logic [RATE_W-1:0]    RST_CPS_US      = 13'd100;
  localparam logic [RATE_MS_W-1:0] RST_CPS_MS      = 23'd100000;
  localparam logic [RATE_W-1:0]    RST_UNIT_1024NS = 13'd102;
  localparam logic [RATE_W-1:0]    RST_UNIT_US     = 13'd100;
  localparam logic [RATE_MS_W-1:0] RST_UNIT_MS     = 23'd100000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_DIFF,
    S_CMP,
    S_MUL,
    S_MULFIN,
    S_DIV,
    S_DIVFIN,
    S_DONE
  } state_e;

endpackage : frtc_pkg

/* src/free_running_timebase_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_running_timebase_converter_unit: free-running counter and time math
// Tick/read a counter, convert times to counts, test timeouts and measure
// durations, all through one shared 56-bit adder under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transaction content
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: first_value, second_value
//  m_axis   | out       | tdata: result_value, status
//  cfg      | in        | write enable, register index, write data
//
// Conversions take 32 shift-add steps and durations 32 restoring divide steps;
// the single shared adder takes one step per cycle. Input is accepted only in
// idle.
// Reset: counter clears, registers take their defaults, no clearing pass.
// Stalls: a finished result waits in the done state until the output register
// is free; the output register itself frees in the cycle m_axis_tready_i is high.

module free_running_timebase_converter_unit #(
  parameter int COUNTER_BITS = frtc_pkg::COUNTER_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [31:0] first_value, [63:32] second_value
  input  logic [frtc_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // [3:0] command
  input  logic [frtc_pkg::CMD_W-1:0]            s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [31:0] result_value, [33:32] status, [39:34] zero
  output logic [frtc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  input  logic                                  cfg_we_i,
  input  logic [frtc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [frtc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import frtc_pkg::*;

  localparam int CB = COUNTER_BITS;

  // configuration
  logic                 count_down_q;
  logic [RATE_W-1:0]    cps_1024ns_q, cps_us_q, unit_1024ns_q, unit_us_q;
  logic [RATE_MS_W-1:0] cps_ms_q, unit_ms_q;

  // control
  state_e          state_q, state_d;
  logic [CB-1:0]   tick_q;
  logic            out_valid_q;
  logic            out_free;
  logic            in_fire;

  // datapath
  logic [CMD_W-1:0]     cmd_q;
  logic [CB-1:0]        opx_q, opy_q;      // start/diff and end/limit
  logic [ADD_W-1:0]     acc_q;             // product accumulator
  logic [DATA_W-1:0]    mplier_q;          // multiplier bits, then dividend/quotient
  logic [RATE_MS_W-1:0] den_q;             // multiplicand or divisor
  logic [RATE_MS_W-1:0] rem_q;
  logic [STEP_W-1:0]    cnt_q;
  logic                 coarse_q;
  logic [DATA_W-1:0]    res_q, out_res_q;
  logic [ST_W-1:0]      st_q, out_st_q;

  // shared adder
  logic [ADD_W-1:0] add_a, add_b, add_sum;
  logic             add_cin;

  logic [RATE_MS_W:0]   rem_sh;
  logic [DATA_W-1:0]    diff32;
  logic                 diff_coarse;
  logic [RATE_MS_W-1:0] sel_unit;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - DATA_W - ST_W)'(0), out_st_q, out_res_q};

  assign rem_sh      = {rem_q, mplier_q[DATA_W-1]};
  assign diff32      = DATA_W'(add_sum[CB-1:0]);
  assign diff_coarse = |diff32[DATA_W-1:COARSE_LSB];
  assign add_sum     = add_a + add_b + ADD_W'(add_cin);

  // divisor picked by the incoming command
  always_comb begin
    case (s_axis_tuser_i)
      CMD_DUR_NS: sel_unit = RATE_MS_W'(unit_1024ns_q);
      CMD_DUR_US: sel_unit = RATE_MS_W'(unit_us_q);
      default:    sel_unit = unit_ms_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser_i)
            CMD_TICK:                           state_d = S_TICK;
            CMD_NS2CNT, CMD_US2CNT, CMD_MS2CNT: state_d = S_MUL;
            CMD_TIMEOUT:                        state_d = S_DIFF;
            CMD_DUR_NS, CMD_DUR_US, CMD_DUR_MS:
              state_d = (sel_unit == '0) ? S_DONE : S_DIFF;
            default:                            state_d = S_DONE;
          endcase
        end
      end
      S_TICK:   state_d = S_DONE;
      S_DIFF:   state_d = (cmd_q == CMD_TIMEOUT) ? S_CMP : S_DIV;
      S_CMP:    state_d = S_DONE;
      S_MUL:    state_d = (cnt_q == '0) ? S_MULFIN : S_MUL;
      S_MULFIN: state_d = S_DONE;
      S_DIV:    state_d = (cnt_q == '0) ? S_DIVFIN : S_DIV;
      S_DIVFIN: state_d = S_DONE;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // operand selection for the shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      S_TICK: begin
        // +1, or -1 as adding all ones
        add_a   = ADD_W'(tick_q);
        add_b   = count_down_q ? '1 : '0;
        add_cin = !count_down_q;
      end
      S_DIFF: begin
        // count_down: start - end, else end - start
        if (cmd_q == CMD_TIMEOUT) begin
          add_a = count_down_q ? ADD_W'(opx_q) : ADD_W'(tick_q);
          add_b = count_down_q ? ~ADD_W'(tick_q) : ~ADD_W'(opx_q);
        end else begin
          add_a = count_down_q ? ADD_W'(opx_q) : ADD_W'(opy_q);
          add_b = count_down_q ? ~ADD_W'(opy_q) : ~ADD_W'(opx_q);
        end
        add_cin = 1'b1;
      end
      S_CMP: begin
        add_a   = ADD_W'(opx_q);
        add_b   = ~ADD_W'(opy_q);
        add_cin = 1'b1;
      end
      S_MUL: begin
        add_a = {acc_q[ADD_W-2:0], 1'b0};
        add_b = mplier_q[DATA_W-1] ? ADD_W'(den_q) : '0;
      end
      S_MULFIN: begin
        add_a = acc_q;
        add_b = NS_ROUND;
      end
      S_DIV: begin
        add_a   = ADD_W'(rem_sh);
        add_b   = ~ADD_W'(den_q);
        add_cin = 1'b1;
      end
      S_DIVFIN: begin
        // round up when a remainder is left
        add_a   = ADD_W'(mplier_q);
        add_cin = (rem_q != '0);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      tick_q        <= '0;
      out_valid_q   <= 1'b0;
      count_down_q  <= 1'b1;
      cps_1024ns_q  <= RST_CPS_1024NS;
      cps_us_q      <= RST_CPS_US;
      cps_ms_q      <= RST_CPS_MS;
      unit_1024ns_q <= RST_UNIT_1024NS;
      unit_us_q     <= RST_UNIT_US;
      unit_ms_q     <= RST_UNIT_MS;
    end else begin
      state_q <= state_d;
      if (state_q == S_TICK) begin
        tick_q <= add_sum[CB-1:0];
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COUNT_DOWN:  count_down_q  <= cfg_wdata_i[0];
          REG_CPS_1024NS:  cps_1024ns_q  <= cfg_wdata_i[RATE_W-1:0];
          REG_CPS_US:      cps_us_q      <= cfg_wdata_i[RATE_W-1:0];
          REG_CPS_MS:      cps_ms_q      <= cfg_wdata_i;
          REG_UNIT_1024NS: unit_1024ns_q <= cfg_wdata_i[RATE_W-1:0];
          REG_UNIT_US:     unit_us_q     <= cfg_wdata_i[RATE_W-1:0];
          REG_UNIT_MS:     unit_ms_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_q    <= s_axis_tuser_i;
          opx_q    <= s_axis_tdata_i[CB-1:0];
          opy_q    <= s_axis_tdata_i[DATA_W +: CB];
          mplier_q <= s_axis_tdata_i[DATA_W-1:0];
          acc_q    <= '0;
          rem_q    <= '0;
          cnt_q    <= STEP_W'(DATA_W - 1);
          coarse_q <= 1'b0;
          res_q    <= '0;
          st_q     <= ST_OK;
          case (s_axis_tuser_i)
            CMD_READ:   res_q <= DATA_W'(tick_q);
            CMD_NS2CNT: den_q <= RATE_MS_W'(cps_1024ns_q);
            CMD_US2CNT: den_q <= RATE_MS_W'(cps_us_q);
            CMD_MS2CNT: den_q <= cps_ms_q;
            CMD_DUR_NS, CMD_DUR_US, CMD_DUR_MS: begin
              den_q <= sel_unit;
              if (sel_unit == '0) st_q <= ST_DIV0;
            end
            default: ;
          endcase
        end
      end
      S_TICK: res_q <= DATA_W'(add_sum[CB-1:0]);
      S_DIFF: begin
        opx_q <= add_sum[CB-1:0];
        // ns duration: fine path scales by 1024 before dividing
        if (cmd_q == CMD_DUR_NS && !diff_coarse) begin
          mplier_q <= diff32 << NS_SHIFT;
        end else begin
          mplier_q <= diff32;
        end
        coarse_q <= (cmd_q == CMD_DUR_NS) && diff_coarse;
      end
      S_CMP: res_q <= DATA_W'(!add_sum[ADD_W-1]);
      S_MUL: begin
        acc_q    <= add_sum;
        mplier_q <= {mplier_q[DATA_W-2:0], 1'b0};
        cnt_q    <= cnt_q - 1'b1;
      end
      S_MULFIN: begin
        if (cmd_q == CMD_NS2CNT) begin
          if (|add_sum[ADD_W-1:DATA_W]) begin
            res_q <= '1;
            st_q  <= ST_OVF;
          end else begin
            res_q <= add_sum[NS_SHIFT +: DATA_W];
          end
        end else if (|acc_q[ADD_W-1:DATA_W]) begin
          res_q <= '1;
          st_q  <= ST_OVF;
        end else begin
          res_q <= acc_q[DATA_W-1:0];
        end
      end
      S_DIV: begin
        // restoring step: keep the trial difference when it is not negative
        rem_q    <= add_sum[ADD_W-1] ? rem_sh[RATE_MS_W-1:0] : add_sum[RATE_MS_W-1:0];
        mplier_q <= {mplier_q[DATA_W-2:0], !add_sum[ADD_W-1]};
        cnt_q    <= cnt_q - 1'b1;
      end
      S_DIVFIN: begin
        if (coarse_q) begin
          if (|add_sum[DATA_W-1:COARSE_LSB]) begin
            res_q <= '1;
            st_q  <= ST_OVF;
          end else begin
            res_q <= add_sum[DATA_W-1:0] << NS_SHIFT;
          end
        end else begin
          res_q <= add_sum[DATA_W-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_res_q <= res_q;
          out_st_q  <= st_q;
        end
      end
      default: ;
    endcase
  end

endmodule : free_running_timebase_converter_unit

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for free_running_timebase_converter_unit
// Sends counter, conversion, timeout and duration commands on the input stream,
// keeps its own model of the tick counter and the rate registers, and compares
// every output transaction with the predicted value and status. It covers
// directed extreme cases, randomized register settings with random traffic,
// output backpressure, and a run with no idling at the end.
// ----------------------------------------------------------------------------
module tb;
  import frtc_pkg::*;

  localparam int HOLD_CYCLES  = 300;   // long output stall, block must fill up

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] value;
  } result_t;

  // DUT connections
  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;    // [31:0] first_value, [63:32] second_value
  logic [CMD_W-1:0]        s_axis_tuser;    // [3:0] command
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;    // [31:0] result_value, [33:32] status
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  // shadow of the block state
  logic [DATA_W-1:0]    tick_count;
  logic                 down_mode;
  logic [RATE_W-1:0]    rate_ns;
  logic [RATE_W-1:0]    rate_us;
  logic [RATE_MS_W-1:0] rate_ms;
  logic [RATE_W-1:0]    div_ns;
  logic [RATE_W-1:0]    div_us;
  logic [RATE_MS_W-1:0] div_ms;

  result_t     pending_results[$];
  int unsigned mismatch_count;
  bit          idle_en;      // random gaps on both sides
  bit          hold_output;  // request a long stall on the output side

  free_running_timebase_converter_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // rounded-up division, never wraps in the rounding add
  function automatic logic [63:0] div_round_up(logic [63:0] num, logic [63:0] den);
    return (num + den - 64'd1) / den;
  endfunction

  // elapsed counts between two counter samples, in the counting direction
  function automatic logic [DATA_W-1:0] elapsed(logic [DATA_W-1:0] from_cnt,
                                                logic [DATA_W-1:0] to_cnt);
    return down_mode ? from_cnt - to_cnt : to_cnt - from_cnt;
  endfunction

  // Work out the result of one command and advance the shadow counter.
  function automatic result_t convert_command(logic [CMD_W-1:0] cmd,
                                              logic [DATA_W-1:0] first_val,
                                              logic [DATA_W-1:0] second_val);
    result_t           r;
    logic [63:0]       wide;
    logic [DATA_W-1:0] span;
    logic [63:0]       divisor;
    r.value  = '0;
    r.status = ST_OK;
    wide     = '0;
    case (cmd)
      CMD_TICK: begin
        tick_count = down_mode ? tick_count - 1'b1 : tick_count + 1'b1;
        r.value    = tick_count;
      end
      CMD_READ: r.value = tick_count;
      CMD_NS2CNT, CMD_US2CNT, CMD_MS2CNT: begin
        if (cmd == CMD_NS2CNT) wide = 64'(rate_ns) * 64'(first_val) + 64'd1023;
        else if (cmd == CMD_US2CNT) wide = 64'(rate_us) * 64'(first_val);
        else wide = 64'(rate_ms) * 64'(first_val);
        if (wide > 64'hFFFF_FFFF) begin
          r.value  = '1;
          r.status = ST_OVF;
        end else begin
          r.value = (cmd == CMD_NS2CNT) ? wide[41:10] : wide[31:0];
        end
      end
      CMD_TIMEOUT: r.value = (elapsed(first_val, tick_count) >= second_val) ? 32'd1 : 32'd0;
      CMD_DUR_NS, CMD_DUR_US, CMD_DUR_MS: begin
        if (cmd == CMD_DUR_NS) divisor = 64'(div_ns);
        else if (cmd == CMD_DUR_US) divisor = 64'(div_us);
        else divisor = 64'(div_ms);
        span = elapsed(first_val, second_val);
        if (divisor == 64'd0) begin
          r.status = ST_DIV0;
        end else begin
          if (cmd != CMD_DUR_NS) wide = div_round_up(64'(span), divisor);
          // coarse path once the span no longer fits 22 bits
          else if (span[31:COARSE_LSB] != '0) wide = div_round_up(64'(span), divisor) << 10;
          else wide = div_round_up(64'(span) << 10, divisor);
          if (wide > 64'hFFFF_FFFF) begin
            r.value  = '1;
            r.status = ST_OVF;
          end else begin
            r.value = wide[31:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall generator and result checker
  // ---------------------------------------------------------------------------

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_output = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, expected none, actual value %h status %0d",
                 $time, m_axis_tdata[31:0], m_axis_tdata[33:32]);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.value) begin
          mismatch_count++;
          $display("%0t: result_value mismatch, expected %h actual %h", $time,
                   exp_r.value, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[33:32] !== exp_r.status) begin
          mismatch_count++;
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   exp_r.status, m_axis_tdata[33:32]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------

  // One input transaction. Returns at the accepting edge so a following call
  // can keep tvalid high without a gap.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] first_val,
                              logic [DATA_W-1:0] second_val);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second_val, first_val};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(convert_command(cmd, first_val, second_val));
  endtask

  // drop tvalid and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // only called while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      REG_COUNT_DOWN:  down_mode = val[0];
      REG_CPS_1024NS:  rate_ns   = val[RATE_W-1:0];
      REG_CPS_US:      rate_us   = val[RATE_W-1:0];
      REG_CPS_MS:      rate_ms   = val[RATE_MS_W-1:0];
      REG_UNIT_1024NS: div_ns    = val[RATE_W-1:0];
      REG_UNIT_US:     div_us    = val[RATE_W-1:0];
      REG_UNIT_MS:     div_ms    = val[RATE_MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(bit dn, int unsigned cns, int unsigned cus, int unsigned cms,
                                int unsigned uns, int unsigned uus, int unsigned ums);
    write_reg(REG_COUNT_DOWN, CFG_DATA_W'(dn));
    write_reg(REG_CPS_1024NS, CFG_DATA_W'(cns));
    write_reg(REG_CPS_US, CFG_DATA_W'(cus));
    write_reg(REG_CPS_MS, CFG_DATA_W'(cms));
    write_reg(REG_UNIT_1024NS, CFG_DATA_W'(uns));
    write_reg(REG_UNIT_US, CFG_DATA_W'(uus));
    write_reg(REG_UNIT_MS, CFG_DATA_W'(ums));
  endtask

  // value of random bit length, so small and large magnitudes both show up
  function automatic logic [DATA_W-1:0] random_magnitude();
    int unsigned nbits;
    nbits = $urandom_range(0, 32);
    return $urandom & (32'hFFFF_FFFF >> (32 - nbits));
  endfunction

  function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      2:       return $urandom_range(lo, lo + 15);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Random command with operands shaped around the current counter so that
  // timeouts and durations land on both sides of their thresholds.
  task automatic send_random_command();
    int unsigned       pick;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] first_val;
    logic [DATA_W-1:0] second_val;
    pick       = $urandom_range(0, 99);
    span       = random_magnitude();
    first_val  = $urandom;
    second_val = $urandom;
    if (pick < 15) begin
      send_command(CMD_TICK, first_val, second_val);
    end else if (pick < 20) begin
      send_command(CMD_READ, first_val, second_val);
    end else if (pick < 50) begin
      case ($urandom_range(0, 2))
        0:       send_command(CMD_NS2CNT, span, second_val);
        1:       send_command(CMD_US2CNT, span, second_val);
        default: send_command(CMD_MS2CNT, span, second_val);
      endcase
    end else if (pick < 65) begin
      first_val = down_mode ? tick_count + span : tick_count - span;
      if ($urandom_range(0, 3) != 0) second_val = span + $urandom_range(0, 2) - 1;
      send_command(CMD_TIMEOUT, first_val, second_val);
    end else begin
      if ($urandom_range(0, 7) != 0) second_val = down_mode ? first_val - span : first_val + span;
      case ($urandom_range(0, 2))
        0:       send_command(CMD_DUR_NS, first_val, second_val);
        1:       send_command(CMD_DUR_US, first_val, second_val);
        default: send_command(CMD_DUR_MS, first_val, second_val);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // defaults after reset: count down, rates 103/100/100000, units 102/100/100000
  task automatic test_reset_defaults();
    send_command(CMD_READ, 32'h0, 32'h0);
    send_command(CMD_TICK, 32'h0, 32'h0);             // wraps down to all ones
    send_command(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_NS2CNT, 32'h0, 32'h0);
    send_command(CMD_NS2CNT, 32'hFFFF_FFFF, 32'h0);   // saturates
    send_command(CMD_US2CNT, 32'd42949672, 32'h0);    // just below the limit
    send_command(CMD_US2CNT, 32'hFFFF_FFFF, 32'h0);
    send_command(CMD_MS2CNT, 32'd42949, 32'h0);
    send_command(CMD_MS2CNT, 32'd42950, 32'h0);       // first overflowing amount
    send_command(CMD_TIMEOUT, tick_count, 32'h0);     // zero length: timed out
    send_command(CMD_TIMEOUT, tick_count, 32'hFFFF_FFFF);
    send_command(CMD_DUR_NS, 32'h003F_FFFF, 32'h0);   // widest fine-path span
    send_command(CMD_DUR_NS, 32'h0040_0000, 32'h0);   // first coarse-path span
    send_command(CMD_DUR_NS, 32'hFFFF_FFFF, 32'h0);   // coarse result saturates
    send_command(CMD_DUR_US, 32'h0, 32'h0);
    send_command(CMD_DUR_MS, 32'h0, 32'h1);           // span wraps to all ones
    drain_results();
  endtask

  // count up, zero divisors, largest and smallest rates
  task automatic test_register_extremes();
    write_all_regs(1'b0, 4096, 4096, 4194304, 0, 0, 0);
    send_command(CMD_DUR_NS, 32'h5, 32'h9);           // zero divisors
    send_command(CMD_DUR_US, 32'h5, 32'h9);
    send_command(CMD_DUR_MS, 32'h5, 32'h9);
    send_command(CMD_TICK, 32'h0, 32'h0);
    send_command(CMD_TICK, 32'h0, 32'h0);             // wraps up to zero
    send_command(CMD_US2CNT, 32'h1, 32'h0);
    send_command(CMD_MS2CNT, 32'd1023, 32'h0);
    send_command(CMD_MS2CNT, 32'd1024, 32'h0);        // exactly 2^32: overflow
    drain_results();
    write_all_regs(1'b0, 1, 1, 1, 1, 1, 1);
    send_command(CMD_NS2CNT, 32'h1, 32'h0);
    send_command(CMD_DUR_NS, 32'h0, 32'h0040_0000);   // coarse, unit one: overflow
    send_command(CMD_DUR_US, 32'h0, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // random register settings, first the low and high corners
  task automatic test_random_settings(int unsigned phases, int unsigned per_phase);
    for (int unsigned ph = 0; ph < phases; ph++) begin
      drain_results();
      idle_en = ($urandom_range(0, 3) != 0);
      if (ph == 0) write_all_regs(1'b0, 1, 1, 1, 0, 0, 0);
      else if (ph == 1) write_all_regs(1'b1, 4096, 4096, 4194304, 4096, 4096, 4194304);
      else write_all_regs($urandom_range(0, 1), pick_setting(1, 4096), pick_setting(1, 4096),
                          pick_setting(1, 4194304), pick_setting(0, 4096),
                          pick_setting(0, 4096), pick_setting(0, 4194304));
      repeat (per_phase) send_random_command();
    end
    drain_results();
  endtask

  // output stalls for a long time while input keeps coming
  task automatic test_output_backpressure();
    idle_en     = 1'b1;
    hold_output = 1'b1;
    repeat (20) send_random_command();
    drain_results();
  endtask

  // input goes quiet until every result is back, then resumes
  task automatic test_input_pause();
    idle_en = 1'b1;
    repeat (8) send_random_command();
    drain_results();
    repeat (8) send_random_command();
    drain_results();
  endtask

  // full rate on both sides
  task automatic test_full_rate(int unsigned count);
    idle_en = 1'b0;
    write_all_regs($urandom_range(0, 1), pick_setting(1, 4096), pick_setting(1, 4096),
                   pick_setting(1, 4194304), pick_setting(1, 4096),
                   pick_setting(1, 4096), pick_setting(1, 4194304));
    repeat (count) send_random_command();
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    idle_en        = 1'b1;
    hold_output    = 1'b0;
    tick_count     = '0;
    down_mode      = 1'b1;
    rate_ns        = RST_CPS_1024NS;
    rate_us        = RST_CPS_US;
    rate_ms        = RST_CPS_MS;
    div_ns         = RST_UNIT_1024NS;
    div_us         = RST_UNIT_US;
    div_ms         = RST_UNIT_MS;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_settings(8, 130);
    test_output_backpressure();
    test_input_pause();
    test_full_rate(200);

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
